// ----- rtl/core/pitc_pkg.sv -----
// Shared constants for the PI heading turn controller.
// Register indexes, reset values, field widths and turn direction codes.
// No dependencies.
`timescale 1ns / 1ps

package pitc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_Q8  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd5;

	localparam logic [7:0]        RST_PROP_GAIN      = 8'd18;
	localparam logic [7:0]        RST_INTEG_GAIN_Q8  = 8'd51;
	localparam logic signed [8:0] RST_TARGET_HEADING = 9'sd0;
	localparam logic [9:0]        RST_DRIVE_LIMIT    = 10'd549;
	localparam logic [9:0]        RST_BASE_DUTY      = 10'd549;
	localparam logic [7:0]        RST_DEAD_BAND      = 8'd3;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	typedef logic [1:0] turn_dir_t;
	localparam turn_dir_t DIR_NONE  = 2'd0;
	localparam turn_dir_t DIR_LEFT  = 2'd1;
	localparam turn_dir_t DIR_RIGHT = 2'd2;

	// integral kept as 2x sum, one fractional bit
	typedef logic signed [23:0] integ_t;
	typedef logic signed [9:0]  err_t;

endpackage

// ----- rtl/core/pi_heading_turn_controller.sv -----
// PI heading turn controller, top level: error, trapezoidal integral, drive, clamp, duty.
// Depends on pitc_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[8:0] yaw_deg
//  m_      | out | m_tvalid/m_tready  | m_tdata drive, turn_dir, duty, turn_done
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while m_tready is high.
// Four stages: input register, integral update, products, result register.
// The integral and previous error update in the second stage, so the state loop is
// one 26-bit add and a saturate. Bubbles collapse; stalls ripple back stage by stage.
// arst_n clears state and valid flags and loads register defaults.
`timescale 1ns / 1ps

module pi_heading_turn_controller
	import pitc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [8:0] yaw_deg, rest zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [10:0] drive, [12:11] turn_dir,
	                                         // [22:13] duty, [23] turn_done
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [7:0]        prop_gain_q;
	logic [7:0]        integ_gain_q8_q;
	logic signed [8:0] target_heading_q;
	logic [9:0]        drive_limit_q;
	logic [9:0]        base_duty_q;
	logic [7:0]        dead_band_q;

	integ_t integral_q;
	err_t   prev_error_q;
	logic   primed_q;
	logic   finished_q;

	logic en_s1, en_s2, en_s3, en_s4, adv_s2;

	logic              v_s1;
	logic signed [8:0] yaw_s1;

	logic   v_s2, ign_s2, drv_en_s2, done_s2;
	integ_t acc_s2;
	err_t   err_s2;

	logic               v_s3, ign_s3, drv_en_s3, done_s3;
	logic signed [18:0] pe_s3;
	logic signed [32:0] ie_s3;

	logic            v_s4;
	logic [10:0]     drive_s4;
	turn_dir_t       dir_s4;
	logic [9:0]      duty_s4;
	logic            done_s4;

	err_t               err;
	logic signed [25:0] acc_full;
	integ_t             acc_sat;
	logic [8:0]         mag_yaw;
	logic               in_band;

	logic signed [18:0] pe;
	logic signed [32:0] ie;

	logic signed [27:0] pe_sh;
	logic signed [33:0] num, num_adj;
	logic signed [24:0] quo, lim, d;
	logic [10:0]        drv;
	logic [9:0]         mag;
	logic [10:0]        dt;
	logic [10:0]        drive_n;
	turn_dir_t          dir_n;
	logic [9:0]         duty_n;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= RST_PROP_GAIN;
			integ_gain_q8_q  <= RST_INTEG_GAIN_Q8;
			target_heading_q <= RST_TARGET_HEADING;
			drive_limit_q    <= RST_DRIVE_LIMIT;
			base_duty_q      <= RST_BASE_DUTY;
			dead_band_q      <= RST_DEAD_BAND;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data[7:0];
				REG_INTEG_GAIN_Q8:  integ_gain_q8_q  <= cfg_data[7:0];
				REG_TARGET_HEADING: target_heading_q <= cfg_data[8:0];
				REG_DRIVE_LIMIT:    drive_limit_q    <= cfg_data;
				REG_BASE_DUTY:      base_duty_q      <= cfg_data;
				REG_DEAD_BAND:      dead_band_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign adv_s2   = v_s1 && en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_s1)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid)
			yaw_s1 <= s_tdata[8:0];
	end

	// integral update
	always_comb begin
		err      = {yaw_s1[8], yaw_s1} - {target_heading_q[8], target_heading_q};
		acc_full = 26'(integral_q) + 26'(err) + 26'(prev_error_q);
		if (!acc_full[25] && acc_full[24:23] != 2'b00)
			acc_sat = {1'b0, {23{1'b1}}};
		else if (acc_full[25] && acc_full[24:23] != 2'b11)
			acc_sat = {1'b1, 23'd0};
		else
			acc_sat = acc_full[23:0];
		mag_yaw = yaw_s1[8] ? 9'(-yaw_s1) : 9'(yaw_s1);
		in_band = mag_yaw <= {1'b0, dead_band_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			prev_error_q <= '0;
			primed_q     <= 1'b0;
			finished_q   <= 1'b0;
		end else if (adv_s2 && !finished_q) begin
			integral_q   <= acc_sat;
			prev_error_q <= err;
			primed_q     <= 1'b1;
			if (in_band)
				finished_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			acc_s2    <= acc_sat;
			err_s2    <= err;
			ign_s2    <= finished_q;
			drv_en_s2 <= primed_q;
			done_s2   <= finished_q || in_band;
		end
	end

	// products
	assign pe = $signed({1'b0, prop_gain_q}) * err_s2;
	assign ie = $signed({1'b0, integ_gain_q8_q}) * acc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			pe_s3     <= pe;
			ie_s3     <= ie;
			ign_s3    <= ign_s2;
			drv_en_s3 <= drv_en_s2;
			done_s3   <= done_s2;
		end
	end

	// scale by 1/512 toward zero, clamp, duty
	always_comb begin
		pe_sh   = {pe_s3, 9'd0};
		num     = 34'(pe_sh) + 34'(ie_s3);
		num_adj = num + (num[33] ? 34'sd511 : 34'sd0);
		quo     = num_adj[33:9];
		lim     = $signed({15'd0, drive_limit_q});
		if (quo > lim)
			d = lim;
		else if (quo < -lim)
			d = -lim;
		else
			d = quo;
		drv = d[10:0];
		mag = drv[10] ? 10'(-drv) : drv[9:0];
		dt  = {1'b0, base_duty_q} - {1'b0, mag};
		drive_n = drv;
		dir_n   = DIR_NONE;
		duty_n  = '0;
		if (ign_s3) begin
			drive_n = '0;
		end else if (drv_en_s3 && drv != '0) begin
			dir_n  = drv[10] ? DIR_RIGHT : DIR_LEFT;
			duty_n = dt[10] ? 10'd0 : dt[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en_s4)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			drive_s4 <= drive_n;
			dir_s4   <= dir_n;
			duty_s4  <= duty_n;
			done_s4  <= done_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {done_s4, duty_s4, dir_s4, drive_s4};

endmodule

// ----- rtl/core/pitc_checker.sv -----
// Port-level checks for the PI heading turn controller, and their bind.
// Depends on pitc_pkg and pi_heading_turn_controller.
`timescale 1ns / 1ps

module pitc_checker
	import pitc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	logic [10:0] drive;
	turn_dir_t   dir;
	logic [9:0]  duty;

	assign drive = m_tdata[10:0];
	assign dir   = m_tdata[12:11];
	assign duty  = m_tdata[22:13];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_idle_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dir == DIR_NONE |-> duty == 10'd0)
		else $error("duty without direction");

	a_left_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dir == DIR_LEFT |-> !drive[10] && drive != 11'd0)
		else $error("left turn with non-positive drive");

	a_right_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && dir == DIR_RIGHT |-> drive[10])
		else $error("right turn with non-negative drive");

endmodule

bind pi_heading_turn_controller pitc_checker u_pitc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
